FILE: src/ukvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ukvt_pkg
// types, command and status codes shared by the key/value table
// ----------------------------------------------------------------------------
package ukvt_pkg;

  localparam int KEY_BITS   = 32;
  localparam int INFO_BITS  = 32;
  localparam int FUNC_W     = 3;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 5;
  localparam int CAP_W      = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // command codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MIN    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_MAX    = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [KEY_BITS-1:0]  key;
    logic [INFO_BITS-1:0] info;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [KEY_BITS-1:0]  result_key;
    logic [INFO_BITS-1:0] result_info;
    logic [COUNT_W-1:0]   entry_count;
  } out_t;

  // one stored table entry
  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [INFO_BITS-1:0] info;
  } entry_t;

endpackage
`default_nettype wire

FILE: src/ukvt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ukvt_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ukvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: src/unsorted_key_value_table.sv
`timescale 1ns / 1ps
`default_nettype none
// sequencing: a command that needs no scan (full, empty, bad code, insert into an empty
//   table) goes straight to the response; insert, lookup, min and max scan the stored
//   entries (insert and lookup stop early on a hit); remove scans, reads the last entry
//   and writes it into the hole
// throughput: one transaction at a time, set by the single read port walking the table
// reset: synchronous active-low, clears the entry count and restores capacity to 16
// ----------------------------------------------------------------------------
// unsorted_key_value_table
// key/data dictionary kept as a packed unsorted array in one ram
// ----------------------------------------------------------------------------
module unsorted_key_value_table
  import ukvt_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_t              in_data,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_t                  out_data,
  // configuration
  input  wire logic             cfg_wr_en,
  input  wire logic [CAP_W-1:0] cfg_wr_data
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int CMPW   = (CW > CAP_W) ? CW : CAP_W;
  localparam int WORD_W = $bits(entry_t);

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_MOVE_RD = 5'b00100,
    S_MOVE_WR = 5'b01000,
    S_RESP    = 5'b10000
  } state_t;

  // control registers
  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CAP_W-1:0]      cap_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  rdv_r, rdv_nxt;

  // command and working registers
  logic [FUNC_W-1:0]     func_r, func_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [INFO_BITS-1:0]  info_r, info_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [KEY_BITS-1:0]   rkey_r, rkey_nxt;
  logic [INFO_BITS-1:0]  rinfo_r, rinfo_nxt;
  logic                  ins_r, ins_nxt;
  logic [CW-1:0]         issue_r, issue_nxt;
  logic [AW-1:0]         rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]         hit_r, hit_nxt;
  out_t                  out_data_r, out_data_nxt;

  // ram port signals
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  entry_t                ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;
  entry_t                rd_entry;

  logic                  accept;
  logic                  fire;
  logic                  full;
  logic                  rd_issue;
  logic                  rd_last;
  logic                  key_hit;
  logic                  better;
  logic [CW-1:0]         last_idx;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // result leaves the sequencer once the output register is free or being drained
  assign fire = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  // capacity is the written limit saturated to the table depth
  assign full = (count_r == CW'(DEPTH)) || (CMPW'(count_r) >= CMPW'(cap_r));

  assign rd_entry = entry_t'(ram_rdata);
  assign key_hit  = (rd_entry.key == key_r);
  assign rd_last  = ((CW'(rd_idx_r) + CW'(1)) == count_r);
  assign rd_issue = (issue_r < count_r);
  assign last_idx = count_r - CW'(1);

  // first entry seeds the running extreme
  assign better = (rd_idx_r == '0) ||
                  ((func_r == FUNC_MIN) ? (rd_entry.key < rkey_r) : (rd_entry.key > rkey_r));

  // read address: walk the table while scanning, fetch the last entry for a remove
  always_comb begin
    ram_raddr = issue_r[AW-1:0];
    if (state_r == S_MOVE_RD) begin
      ram_raddr = last_idx[AW-1:0];
    end
  end

  // writes: last entry into the hole on remove, append on insert
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_r;
    ram_wdata = rd_entry;
    if (state_r == S_MOVE_WR) begin
      ram_we = 1'b1;
    end else if (fire && ins_r) begin
      ram_we    = 1'b1;
      ram_waddr = count_r[AW-1:0];
      ram_wdata = '{key: key_r, info: info_r};
    end
  end

  ukvt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    rdv_nxt       = 1'b0;
    func_nxt      = func_r;
    key_nxt       = key_r;
    info_nxt      = info_r;
    status_nxt    = status_r;
    rkey_nxt      = rkey_r;
    rinfo_nxt     = rinfo_r;
    ins_nxt       = ins_r;
    issue_nxt     = issue_r;
    rd_idx_nxt    = rd_idx_r;
    hit_nxt       = hit_r;
    out_data_nxt  = out_data_r;

    // output register drains independently of the sequencer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt   = in_data.func;
          key_nxt    = in_data.key;
          info_nxt   = in_data.info;
          status_nxt = ST_OK;
          rkey_nxt   = '0;
          rinfo_nxt  = '0;
          ins_nxt    = 1'b0;
          issue_nxt  = '0;
          state_nxt  = S_SCAN;
          case (in_data.func)
            FUNC_INSERT: begin
              if (full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else if (count_r == '0) begin
                ins_nxt   = 1'b1;
                state_nxt = S_RESP;
              end
            end
            FUNC_REMOVE, FUNC_MIN, FUNC_MAX: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end
            end
            FUNC_LOOKUP: begin
              if (count_r == '0) begin
                status_nxt = ST_NOT_FOUND;
                state_nxt  = S_RESP;
              end
            end
            default: begin
              // unused code: no change, status ok
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // keep one read in flight ahead of the compare
        if (rd_issue) begin
          issue_nxt  = issue_r + CW'(1);
          rdv_nxt    = 1'b1;
          rd_idx_nxt = issue_r[AW-1:0];
        end
        if (rdv_r) begin
          case (func_r)
            FUNC_INSERT: begin
              if (key_hit) begin
                status_nxt = ST_DUPLICATE;
                state_nxt  = S_RESP;
              end else if (rd_last) begin
                ins_nxt   = 1'b1;
                state_nxt = S_RESP;
              end
            end
            FUNC_REMOVE: begin
              if (key_hit) begin
                hit_nxt   = rd_idx_r;
                state_nxt = S_MOVE_RD;
              end else if (rd_last) begin
                status_nxt = ST_NOT_FOUND;
                state_nxt  = S_RESP;
              end
            end
            FUNC_LOOKUP: begin
              if (key_hit) begin
                rinfo_nxt = rd_entry.info;
                state_nxt = S_RESP;
              end else if (rd_last) begin
                status_nxt = ST_NOT_FOUND;
                state_nxt  = S_RESP;
              end
            end
            FUNC_MIN, FUNC_MAX: begin
              if (better) begin
                rkey_nxt = rd_entry.key;
              end
              if (rd_last) begin
                state_nxt = S_RESP;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
          // drop the read pipeline when the scan ends
          if (state_nxt != S_SCAN) begin
            rdv_nxt = 1'b0;
          end
        end
      end

      S_MOVE_RD: begin
        state_nxt = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        count_nxt = count_r - CW'(1);
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (fire) begin
          if (ins_r) begin
            count_nxt = count_r + CW'(1);
          end
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.result_key  = rkey_r;
          out_data_nxt.result_info = rinfo_r;
          out_data_nxt.entry_count = COUNT_W'(ins_r ? (count_r + CW'(1)) : count_r);
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
      rdv_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      rdv_r       <= rdv_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    key_r      <= key_nxt;
    info_r     <= info_nxt;
    status_r   <= status_nxt;
    rkey_r     <= rkey_nxt;
    rinfo_r    <= rinfo_nxt;
    ins_r      <= ins_nxt;
    issue_r    <= issue_nxt;
    rd_idx_r   <= rd_idx_nxt;
    hit_r      <= hit_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above table depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted transaction did not start the sequencer");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result appeared outside the response step");

  a_write_steps: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_MOVE_WR) || (state_r == S_RESP))
    else $error("table written outside move or append");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE_WR) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("remove did not shrink the table by one");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_unsorted_key_value_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unsorted_key_value_table
// self-checking bench for the key/value table: a short list of directed
// commands, then random phases of insert, remove, lookup, min, max and spare
// codes under changing capacity limits, checked against hand-written results
// or against a shadow copy of the table
module tb_unsorted_key_value_table;
  import ukvt_pkg::*;

  localparam int DEPTH         = 16;
  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 8;
  localparam int WATCHDOG_MAX  = 4000;  // cycles with no transaction on any channel
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 130;
  localparam int POOL_SIZE     = 20;
  localparam int MAX_REPORTS   = 10;
  localparam int DRAIN_CYCLES  = 30;    // longer than the slowest command, a remove

  // command codes the block accepts but does nothing with
  localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_C = 3'd7;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_t              in_data;
  logic             out_valid;
  logic             out_stall;
  out_t             out_data;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;

  unsorted_key_value_table #(
    .DEPTH (DEPTH)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // --------------------------------------------------------------------------
  // shadow table: our own copy of the stored pairs, fill level and capacity
  // --------------------------------------------------------------------------
  logic [KEY_BITS-1:0]  shadow_key  [DEPTH];
  logic [INFO_BITS-1:0] shadow_info [DEPTH];
  int                   shadow_fill = 0;
  logic [CAP_W-1:0]     shadow_cap  = CAP_RESET;

  // results still owed by the block, oldest first
  out_t pending_results[$];

  // bookkeeping for the summary
  int mismatch_count = 0;
  int cmds_sent      = 0;
  int results_seen   = 0;
  int caps_written   = 0;
  int peak_fill      = 0;
  int status_hits [5] = '{default: 0};
  int idle_pct       = 0;   // chance of an idle burst, shared by both sides

  // works out the result of one command and updates the shadow table
  function automatic out_t apply_command(input in_t c);
    out_t                r;
    int                  hit;
    int                  lim;
    logic [KEY_BITS-1:0] best;
    r      = '0;
    r.status = ST_OK;
    // the limit saturates at the table depth
    lim = (int'(shadow_cap) > DEPTH) ? DEPTH : int'(shadow_cap);
    hit = -1;
    for (int i = 0; i < shadow_fill; i++) begin
      if (hit < 0 && shadow_key[i] == c.key) hit = i;
    end
    case (c.func)
      FUNC_INSERT: begin
        // full is reported before any duplicate search
        if (shadow_fill >= lim) r.status = ST_FULL;
        else if (hit >= 0) r.status = ST_DUPLICATE;
        else begin
          shadow_key[shadow_fill]  = c.key;
          shadow_info[shadow_fill] = c.info;
          shadow_fill++;
        end
      end
      FUNC_REMOVE: begin
        if (shadow_fill == 0) r.status = ST_EMPTY;
        else if (hit < 0) r.status = ST_NOT_FOUND;
        else begin
          // last entry is moved into the hole
          shadow_fill--;
          shadow_key[hit]  = shadow_key[shadow_fill];
          shadow_info[hit] = shadow_info[shadow_fill];
        end
      end
      FUNC_LOOKUP: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else r.result_info = shadow_info[hit];
      end
      FUNC_MIN, FUNC_MAX: begin
        if (shadow_fill == 0) r.status = ST_EMPTY;
        else begin
          best = shadow_key[0];
          for (int i = 1; i < shadow_fill; i++) begin
            if (c.func == FUNC_MIN ? (shadow_key[i] < best) : (shadow_key[i] > best))
              best = shadow_key[i];
          end
          r.result_key = best;
        end
      end
      default: ;  // spare codes leave the table alone
    endcase
    r.entry_count = shadow_fill[COUNT_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // directed stimulus list
  // --------------------------------------------------------------------------
  typedef struct {
    bit               is_cap;   // capacity write rather than a command
    logic [CAP_W-1:0] cap;
    in_t              cmd;
    bit               typed;    // expected result written in by hand
    out_t             want;
  } row_t;

  row_t directed_rows[$];

  function automatic void add_row(input logic [FUNC_W-1:0] f, input logic [KEY_BITS-1:0] k,
                                  input logic [INFO_BITS-1:0] d, input bit typed = 1'b0,
                                  input logic [STATUS_W-1:0] st = ST_OK,
                                  input logic [KEY_BITS-1:0] rk = '0,
                                  input logic [INFO_BITS-1:0] ri = '0,
                                  input logic [COUNT_W-1:0] cnt = '0);
    row_t row;
    row.is_cap = 1'b0;
    row.cap    = '0;
    row.cmd    = '{func: f, key: k, info: d};
    row.typed  = typed;
    row.want   = '{status: st, result_key: rk, result_info: ri, entry_count: cnt};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cap(input logic [CAP_W-1:0] v);
    row_t row;
    row        = '{is_cap: 1'b1, cap: v, cmd: '0, typed: 1'b0, want: '0};
    directed_rows.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------

  // drops valid for a hold-off whose length is set by n
  task automatic hold_off(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // offers one command and books its expected result once it is taken
  task automatic send_cmd(input in_t c, input bit typed, input out_t want);
    out_t predicted;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_command(c);
    pending_results.push_back(typed ? want : predicted);
    cmds_sent++;
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
  endtask

  // capacity is only changed with the table idle and nothing owed
  task automatic write_capacity(input logic [CAP_W-1:0] v);
    hold_off(1);
    while (pending_results.size() != 0) @(posedge clk);
    // short settle so the last write-back is behind us
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_cap = v;
    caps_written++;
  endtask

  // --------------------------------------------------------------------------
  // receiver side: random stall bursts, none while idle_pct is zero
  // --------------------------------------------------------------------------
  initial begin : stall_driver
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_pct == 0) begin
        stall_left = 0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < idle_pct / 3) begin
        stall_left = $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checker: every transaction on the result channel against the
  // oldest expectation, field by field
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (!$isunknown(out_data.status) && out_data.status <= ST_DUPLICATE)
        status_hits[out_data.status]++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result with nothing outstanding: status %0d key %h info %h count %0d",
                   $realtime, out_data.status, out_data.result_key, out_data.result_info,
                   out_data.entry_count);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.result_key !== want.result_key ||
            out_data.result_info !== want.result_info ||
            out_data.entry_count !== want.entry_count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch: expected status %0d key %h info %h count %0d, got %0d %h %h %0d",
                     $realtime, want.status, want.result_key, want.result_info,
                     want.entry_count, out_data.status, out_data.result_key,
                     out_data.result_info, out_data.entry_count);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: gives up when no transaction moves for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("%0t: timeout, %0d results still outstanding", $realtime,
                 pending_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    logic [CAP_W-1:0]    phase_cap [RANDOM_PHASES];
    int                  phase_idle [RANDOM_PHASES];
    int                  phase_ins  [RANDOM_PHASES];
    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
    in_t                 c;
    int                  pick;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;

    // directed part, starting from the reset state (capacity 16, empty)
    add_row(FUNC_MIN,    '0,            '0,            1, ST_EMPTY);
    add_row(FUNC_MAX,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_EMPTY);
    add_row(FUNC_REMOVE, 32'd5,         '0,            1, ST_EMPTY);
    add_row(FUNC_LOOKUP, 32'd5,         '0,            1, ST_NOT_FOUND);
    add_row(FUNC_SPARE_A, 32'hDEAD_BEEF, 32'h1234_5678, 1, ST_OK);
    add_row(FUNC_SPARE_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_OK);
    add_row(FUNC_INSERT, '0,            32'hFFFF_FFFF, 1, ST_OK, '0, '0, 5'd1);
    add_row(FUNC_INSERT, 32'hFFFF_FFFF, '0,            1, ST_OK, '0, '0, 5'd2);
    add_row(FUNC_INSERT, '0,            32'h0000_1234, 1, ST_DUPLICATE, '0, '0, 5'd2);
    add_row(FUNC_LOOKUP, '0,            '0,            1, ST_OK, '0, 32'hFFFF_FFFF, 5'd2);
    add_row(FUNC_MIN,    32'h1234_5678, '0,            1, ST_OK, '0, '0, 5'd2);
    add_row(FUNC_MAX,    '0,            '0,            1, ST_OK, 32'hFFFF_FFFF, '0, 5'd2);
    // keys either side of the sign bit, to catch a signed compare
    add_row(FUNC_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
    add_row(FUNC_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
    add_row(FUNC_MIN,    '0,            '0);
    add_row(FUNC_MAX,    '0,            '0);
    // removing the first entry pulls the last one into its slot
    add_row(FUNC_REMOVE, '0,            '0);
    add_row(FUNC_LOOKUP, 32'h7FFF_FFFF, '0);
    add_row(FUNC_REMOVE, 32'h0001_2345, '0,            1, ST_NOT_FOUND, '0, '0, 5'd3);
    add_row(FUNC_SPARE_C, 32'h5555_AAAA, 32'hAAAA_5555, 1, ST_OK, '0, '0, 5'd3);
    // full wins over duplicate
    add_cap(5'd3);
    add_row(FUNC_INSERT, 32'hFFFF_FFFF, 32'd1,         1, ST_FULL, '0, '0, 5'd3);
    // zero capacity refuses every insert
    add_cap(5'd0);
    add_row(FUNC_INSERT, 32'd42,        32'd1,         1, ST_FULL, '0, '0, 5'd3);
    // capacity below the fill level: nothing is lost, removes still work
    add_cap(5'd1);
    add_row(FUNC_REMOVE, 32'hFFFF_FFFF, '0);
    add_row(FUNC_INSERT, 32'd99,        32'd7);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 25;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cap) write_capacity(directed_rows[i].cap);
      else begin
        if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 14));
        send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random phases: capacity, idling and insert share per phase; the last
    // one runs with no idling at all
    phase_cap  = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd5, 5'd16, 5'd16};
    phase_cap[5] = CAP_W'($urandom_range(1, DEPTH));
    phase_idle = '{30, 20, 25, 0, 35, 20, 0};
    phase_ins  = '{70, 50, 25, 50, 45, 55, 45};

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_capacity(phase_cap[p]);
      idle_pct = phase_idle[p];
      // fresh pool of keys so duplicates and hits are common
      for (int j = 0; j < POOL_SIZE - 4; j++) key_pool[j] = $urandom;
      key_pool[POOL_SIZE-4] = '0;
      key_pool[POOL_SIZE-3] = 32'hFFFF_FFFF;
      key_pool[POOL_SIZE-2] = 32'h8000_0000;
      key_pool[POOL_SIZE-1] = $urandom_range(0, 15);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
          hold_off($urandom_range(1, 14));
        c.key  = $urandom;
        c.info = $urandom;
        if ($urandom_range(0, 99) < phase_ins[p]) begin
          c.func = FUNC_INSERT;
          if ($urandom_range(0, 4) != 0) c.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 40)      c.func = FUNC_REMOVE;
          else if (pick < 70) c.func = FUNC_LOOKUP;
          else if (pick < 82) c.func = FUNC_MIN;
          else if (pick < 94) c.func = FUNC_MAX;
          else                c.func = FUNC_W'(FUNC_SPARE_A + $urandom_range(0, 2));
          if (c.func == FUNC_REMOVE || c.func == FUNC_LOOKUP) begin
            // mostly keys that are really stored, some from the pool
            pick = $urandom_range(0, 9);
            if (shadow_fill > 0 && pick < 6)
              c.key = shadow_key[$urandom_range(0, shadow_fill - 1)];
            else if (pick < 9)
              c.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
          end
        end
        send_cmd(c, 1'b0, '0);
      end
    end

    // let everything drain, then watch a little longer for strays
    hold_off(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d commands and %0d results over %0d capacity writes, peak fill %0d",
             cmds_sent, results_seen, caps_written, peak_fill);
    $display("statuses seen: ok %0d, empty %0d, not found %0d, full %0d, duplicate %0d",
             status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_NOT_FOUND],
             status_hits[ST_FULL], status_hits[ST_DUPLICATE]);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatch_count,
               pending_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: unsorted_key_value_table.f
src/ukvt_pkg.sv
src/ukvt_ram.sv
src/unsorted_key_value_table.sv
tb/tb_unsorted_key_value_table.sv
